// ===== sv/ssp_pkg.sv =====
// ----------------------------------------------------------------------------
// Servo sweep pattern generator package
// Shared widths, register map, reset values and the configuration bundle.
// ----------------------------------------------------------------------------
package ssp_pkg;

	localparam int unsigned ValW   = 16;
	localparam int unsigned StepW  = 12;
	localparam int unsigned CountW = 7;
	localparam int unsigned ProdW  = CountW + StepW;
	localparam int unsigned AmpW   = ProdW + 1;
	localparam int unsigned PatW   = AmpW + 3;
	localparam int unsigned AddrW  = 5;
	localparam int unsigned DataW  = 32;

	typedef enum logic [2:0] {
		REG_PULSE_MIN    = 3'd0,
		REG_PULSE_MAX    = 3'd1,
		REG_CENTER_VALUE = 3'd2,
		REG_STEP_SIZE    = 3'd3,
		REG_STEP_COUNT   = 3'd4,
		REG_DWELL_TICKS  = 3'd5,
		REG_MOTOR_MODE   = 3'd6
	} reg_idx_t;

	localparam logic [ValW-1:0]   RstPulseMin   = 16'd1000;
	localparam logic [ValW-1:0]   RstPulseMax   = 16'd2000;
	localparam logic [ValW-1:0]   RstCenter     = 16'd1500;
	localparam logic [StepW-1:0]  RstStepSize   = 12'd62;
	localparam logic [CountW-1:0] RstStepCount  = 7'd8;
	localparam logic [ValW-1:0]   RstDwellTicks = 16'd40;
	localparam logic              RstMotorMode  = 1'b0;

	typedef struct packed {
		logic [ValW-1:0]   pulse_min;
		logic [ValW-1:0]   pulse_max;
		logic [ValW-1:0]   center_value;
		logic [StepW-1:0]  step_size;
		logic [CountW-1:0] step_count;
		logic [ValW-1:0]   dwell_ticks;
		logic              motor_mode;
	} cfg_t;

endpackage

// ===== sv/ssp_if.sv =====
// ----------------------------------------------------------------------------
// Servo sweep pattern generator channels
// Tick input channel and setpoint result channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ssp_in_if;
	logic                     valid;
	logic                     ready;
	logic                     start_run;
	logic                     load_manual;
	logic [ssp_pkg::ValW-1:0] manual_value;

	modport source (output valid, output start_run, output load_manual,
		output manual_value, input ready);
	modport sink (input valid, input start_run, input load_manual,
		input manual_value, output ready);
endinterface

interface ssp_out_if;
	logic                     valid;
	logic                     ready;
	logic [ssp_pkg::ValW-1:0] setpoint;
	logic                     run_active;

	modport source (output valid, output setpoint, output run_active, input ready);
	modport sink (input valid, input setpoint, input run_active, output ready);
endinterface

// ===== sv/ssp_regs.sv =====
// ----------------------------------------------------------------------------
// Servo sweep pattern generator register file
// APB-style configuration registers with read-back.
// ----------------------------------------------------------------------------
module ssp_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [ssp_pkg::AddrW-1:0] paddr,
	input  logic [ssp_pkg::DataW-1:0] pwdata,
	output logic [ssp_pkg::DataW-1:0] prdata,
	output logic                      pready,
	output ssp_pkg::cfg_t             cfg
);

	ssp_pkg::cfg_t     cfg_q;
	ssp_pkg::reg_idx_t idx;
	logic              wr_en;

	assign pready = 1'b1;
	assign idx    = ssp_pkg::reg_idx_t'(paddr[ssp_pkg::AddrW-1:2]);
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pulse_min    <= ssp_pkg::RstPulseMin;
			cfg_q.pulse_max    <= ssp_pkg::RstPulseMax;
			cfg_q.center_value <= ssp_pkg::RstCenter;
			cfg_q.step_size    <= ssp_pkg::RstStepSize;
			cfg_q.step_count   <= ssp_pkg::RstStepCount;
			cfg_q.dwell_ticks  <= ssp_pkg::RstDwellTicks;
			cfg_q.motor_mode   <= ssp_pkg::RstMotorMode;
		end else if (wr_en) begin
			case (idx)
				ssp_pkg::REG_PULSE_MIN:    cfg_q.pulse_min    <= pwdata[ssp_pkg::ValW-1:0];
				ssp_pkg::REG_PULSE_MAX:    cfg_q.pulse_max    <= pwdata[ssp_pkg::ValW-1:0];
				ssp_pkg::REG_CENTER_VALUE: cfg_q.center_value <= pwdata[ssp_pkg::ValW-1:0];
				ssp_pkg::REG_STEP_SIZE:    cfg_q.step_size    <= pwdata[ssp_pkg::StepW-1:0];
				ssp_pkg::REG_STEP_COUNT:   cfg_q.step_count   <= pwdata[ssp_pkg::CountW-1:0];
				ssp_pkg::REG_DWELL_TICKS:  cfg_q.dwell_ticks  <= pwdata[ssp_pkg::ValW-1:0];
				ssp_pkg::REG_MOTOR_MODE:   cfg_q.motor_mode   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			ssp_pkg::REG_PULSE_MIN:    prdata[ssp_pkg::ValW-1:0]   = cfg_q.pulse_min;
			ssp_pkg::REG_PULSE_MAX:    prdata[ssp_pkg::ValW-1:0]   = cfg_q.pulse_max;
			ssp_pkg::REG_CENTER_VALUE: prdata[ssp_pkg::ValW-1:0]   = cfg_q.center_value;
			ssp_pkg::REG_STEP_SIZE:    prdata[ssp_pkg::StepW-1:0]  = cfg_q.step_size;
			ssp_pkg::REG_STEP_COUNT:   prdata[ssp_pkg::CountW-1:0] = cfg_q.step_count;
			ssp_pkg::REG_DWELL_TICKS:  prdata[ssp_pkg::ValW-1:0]   = cfg_q.dwell_ticks;
			ssp_pkg::REG_MOTOR_MODE:   prdata[0]                   = cfg_q.motor_mode;
			default:                   prdata = '0;
		endcase
	end

endmodule

// ===== sv/ssp_step.sv =====
// ----------------------------------------------------------------------------
// Servo sweep pattern generator step engine
// Input register, run state, pattern arithmetic, clamp and result register.
// ----------------------------------------------------------------------------
module ssp_step (
	input  logic          clk,
	input  logic          arst_n,
	input  ssp_pkg::cfg_t cfg,
	ssp_in_if.sink        in_ch,
	ssp_out_if.source     out_ch
);

	localparam int unsigned ValW   = ssp_pkg::ValW;
	localparam int unsigned CountW = ssp_pkg::CountW;
	localparam int unsigned ProdW  = ssp_pkg::ProdW;
	localparam int unsigned AmpW   = ssp_pkg::AmpW;
	localparam int unsigned PatW   = ssp_pkg::PatW;

	logic              valid_s1;
	logic              start_s1;
	logic              load_s1;
	logic [ValW-1:0]   manual_s1;

	logic              out_valid_q;
	logic [ValW-1:0]   out_setpoint_q;
	logic              out_run_q;

	logic [ValW-1:0]   setpoint_q;
	logic              running_q;
	logic [CountW-1:0] step_index_q;
	logic [ValW-1:0]   tick_count_q;

	logic              advance;
	logic              starting;
	logic              run_now;
	logic [CountW-1:0] idx_eff;
	logic [ValW-1:0]   tick_eff;
	logic [ValW-1:0]   tick_inc;
	logic              active;
	logic              ramp_up;
	logic [CountW-1:0] mult_sel;
	logic [ProdW-1:0]  prod;
	logic [AmpW-1:0]   amp;
	logic signed [PatW-1:0] center_x;
	logic signed [PatW-1:0] pattern;
	logic signed [PatW-1:0] value;
	logic signed [PatW-1:0] lo_x;
	logic signed [PatW-1:0] hi_x;
	logic [ValW-1:0]   clamped;
	logic              running_d;
	logic [CountW-1:0] step_index_d;
	logic [ValW-1:0]   tick_count_d;

	assign advance      = valid_s1 & (~out_valid_q | out_ch.ready);
	assign in_ch.ready  = ~valid_s1 | advance;
	assign out_ch.valid = out_valid_q;
	assign out_ch.setpoint   = out_setpoint_q;
	assign out_ch.run_active = out_run_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready & in_ch.valid) begin
			start_s1  <= in_ch.start_run;
			load_s1   <= in_ch.load_manual;
			manual_s1 <= in_ch.manual_value;
		end
	end

	always_comb begin
		starting = start_s1 & ~running_q;
		run_now  = running_q | start_s1;
		idx_eff  = starting ? '0 : step_index_q;
		tick_eff = starting ? '0 : tick_count_q;
		active   = run_now & (idx_eff < cfg.step_count);
		tick_inc = tick_eff + 1'b1;

		ramp_up  = idx_eff < (cfg.step_count >> 1);
		mult_sel = (cfg.motor_mode & ~ramp_up) ? (cfg.step_count - idx_eff) : idx_eff;
		prod     = ProdW'(mult_sel) * ProdW'(cfg.step_size);
		amp      = cfg.motor_mode ? {prod, 1'b0} : {1'b0, prod};
		center_x = signed'(PatW'(cfg.center_value));
		if (~cfg.motor_mode & ~idx_eff[0]) begin
			pattern = center_x - signed'(PatW'(amp));
		end else begin
			pattern = center_x + signed'(PatW'(amp));
		end

		running_d    = running_q;
		step_index_d = step_index_q;
		tick_count_d = tick_count_q;
		if (active) begin
			value        = pattern;
			running_d    = 1'b1;
			step_index_d = idx_eff;
			tick_count_d = tick_inc;
			if (tick_inc > cfg.dwell_ticks) begin
				tick_count_d = '0;
				step_index_d = idx_eff + 1'b1;
			end
		end else if (run_now) begin
			value        = center_x;
			running_d    = 1'b0;
			step_index_d = '0;
			tick_count_d = tick_eff;
		end else begin
			value = signed'(PatW'(load_s1 ? manual_s1 : setpoint_q));
		end

		lo_x = signed'(PatW'(cfg.pulse_min));
		hi_x = signed'(PatW'(cfg.pulse_max));
		if (value > hi_x) begin
			clamped = cfg.pulse_max;
		end else if (value < lo_x) begin
			clamped = cfg.pulse_min;
		end else begin
			clamped = value[ValW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q   <= ssp_pkg::RstCenter;
			running_q    <= 1'b0;
			step_index_q <= '0;
			tick_count_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (advance) begin
				setpoint_q   <= clamped;
				running_q    <= running_d;
				step_index_q <= step_index_d;
				tick_count_q <= tick_count_d;
				out_valid_q  <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_setpoint_q <= clamped;
			out_run_q      <= running_d;
		end
	end

`ifndef SYNTHESIS
	a_idle_index_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!running_q |-> step_index_q == '0)
		else $error("step index not cleared outside a run");
	a_result_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (out_setpoint_q == setpoint_q) && (out_run_q == running_q))
		else $error("result register disagrees with stored state");
	a_advance_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("processed tick produced no result");
	a_stalled_input_kept: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("input register lost a pending tick");
`endif

endmodule

// ===== sv/servo_sweep_pattern_generator_unit.sv =====
// ----------------------------------------------------------------------------
// Servo sweep pattern generator
// Produces one clamped actuator setpoint per tick, sweeping around a centre.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload
// in_ch     sink       start_run, load_manual, manual_value
// out_ch    source     setpoint, run_active
// APB       slave      seven configuration registers at 4*index
//
// One tick is accepted every cycle while the result is not stalled; each tick
// passes through the input register and then the result register.
// The rate is set by the single multiply, add and clamp between the input
// register and the result register.
// Reset clears the run state and sets the stored setpoint to 1500.
// A stalled result holds the input register; a new tick is still taken when
// the result is taken in the same cycle.
// ----------------------------------------------------------------------------
module servo_sweep_pattern_generator_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	ssp_in_if.sink                    in_ch,
	ssp_out_if.source                 out_ch,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [ssp_pkg::AddrW-1:0] paddr,
	input  logic [ssp_pkg::DataW-1:0] pwdata,
	output logic [ssp_pkg::DataW-1:0] prdata,
	output logic                      pready
);

	ssp_pkg::cfg_t cfg;

	ssp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ssp_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

endmodule

// ===== tb/tb_servo_sweep_pattern_generator_unit.sv =====
// ----------------------------------------------------------------------------
// Servo sweep pattern generator testbench
// Drives ticks through the input channel and takes results from the output
// channel under several idling and stalling phases. Registers are set over
// APB between phases. A behavioural predictor of the sweep, clamp and run
// control forms the expected setpoint of untyped ticks, and each result is
// compared with it in order. A short directed table covers the extremes and
// the corner cases; random phases with random settings follow it.
// ----------------------------------------------------------------------------
module tb_servo_sweep_pattern_generator_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import ssp_pkg::*;

	localparam int QuietLimit  = 5000;
	localparam int NumPhases   = 20;
	localparam int PhaseTicks  = 95;
	localparam int NumRows     = 33;

	typedef struct packed {
		logic            setpoint_unused;
		logic [ValW-1:0] setpoint;
		logic            run_active;
	} tick_res_t;

	typedef struct packed {
		logic            wr_en;
		reg_idx_t        wr_reg;
		logic [ValW-1:0] wr_val;
		logic            send;
		logic            start_run;
		logic            load_manual;
		logic [ValW-1:0] manual_value;
		logic            typed;
		logic [ValW-1:0] typed_sp;
		logic            typed_run;
	} tick_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel, penable, pwrite, pready;
	logic [AddrW-1:0] paddr;
	logic [DataW-1:0] pwdata, prdata;

	ssp_in_if in_ch ();
	ssp_out_if out_ch ();

	servo_sweep_pattern_generator_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Predictor state and its copy of the registers.
	cfg_t            setup;
	logic [ValW-1:0] sp_q;
	logic            run_q;
	logic [CountW-1:0] idx_q;
	logic [ValW-1:0] ticks_q;

	tick_res_t expected_ticks [$];
	int        mismatches = 0;
	int        quiet_cycles = 0;
	int        send_idle_pct = 0;
	int        recv_stall_pct = 0;

	logic            row_typed = 1'b0;
	logic [ValW-1:0] row_sp = '0;
	logic            row_run = 1'b0;

	tick_row_t directed_rows [NumRows] = '{
		'{1'b0, REG_PULSE_MIN, 16'd0, 1'b1, 1'b0, 1'b0, 16'd0, 1'b1, 16'd1500, 1'b0},
		'{1'b0, REG_PULSE_MIN, 16'd0, 1'b1, 1'b0, 1'b1, 16'h0000, 1'b1, 16'd1000, 1'b0},
		'{1'b0, REG_PULSE_MIN, 16'd0, 1'b1, 1'b0, 1'b1, 16'hFFFF, 1'b1, 16'd2000, 1'b0},
		'{1'b0, REG_PULSE_MIN, 16'd0, 1'b1, 1'b0, 1'b1, 16'd1234, 1'b1, 16'd1234, 1'b0},
		'{1'b0, REG_PULSE_MIN, 16'd0, 1'b1, 1'b1, 1'b1, 16'h0000, 1'b1, 16'd1500, 1'b1},
		'{1'b0, REG_PULSE_MIN, 16'd0, 1'b1, 1'b1, 1'b1, 16'h15B3, 1'b1, 16'd1500, 1'b1},
		'{1'b1, REG_DWELL_TICKS, 16'd0, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 16'd0, 1'b0},
		'{1'b0, REG_PULSE_MIN, 16'd0, 1'b1, 1'b0, 1'b0, 16'd0, 1'b0, 16'd0, 1'b0},
		'{1'b0, REG_PULSE_MIN, 16'd0, 1'b1, 1'b0, 1'b1, 16'hAAAA, 1'b0, 16'd0, 1'b0},
		'{1'b0, REG_PULSE_MIN, 16'd0, 1'b1, 1'b0, 1'b0, 16'd0, 1'b0, 16'd0, 1'b0},
		'{1'b1, REG_STEP_COUNT, 16'd0, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 16'd0, 1'b0},
		'{1'b0, REG_PULSE_MIN, 16'd0, 1'b1, 1'b0, 1'b0, 16'd0, 1'b1, 16'd1500, 1'b0},
		'{1'b0, REG_PULSE_MIN, 16'd0, 1'b1, 1'b1, 1'b0, 16'd0, 1'b1, 16'd1500, 1'b0},
		'{1'b1, REG_PULSE_MIN, 16'd3000, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 16'd0, 1'b0},
		'{1'b0, REG_PULSE_MIN, 16'd0, 1'b1, 1'b0, 1'b1, 16'd2500, 1'b1, 16'd2000, 1'b0},
		'{1'b0, REG_PULSE_MIN, 16'd0, 1'b1, 1'b0, 1'b1, 16'd100, 1'b1, 16'd3000, 1'b0},
		'{1'b1, REG_PULSE_MIN, 16'd0, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 16'd0, 1'b0},
		'{1'b1, REG_PULSE_MAX, 16'hFFFF, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 16'd0, 1'b0},
		'{1'b0, REG_PULSE_MIN, 16'd0, 1'b1, 1'b0, 1'b1, 16'h0000, 1'b1, 16'h0000, 1'b0},
		'{1'b0, REG_PULSE_MIN, 16'd0, 1'b1, 1'b0, 1'b1, 16'hFFFF, 1'b1, 16'hFFFF, 1'b0},
		'{1'b1, REG_STEP_SIZE, 16'd4095, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 16'd0, 1'b0},
		'{1'b1, REG_STEP_COUNT, 16'd64, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 16'd0, 1'b0},
		'{1'b1, REG_MOTOR_MODE, 16'd1, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 16'd0, 1'b0},
		'{1'b0, REG_PULSE_MIN, 16'd0, 1'b1, 1'b1, 1'b0, 16'd0, 1'b0, 16'd0, 1'b0},
		'{1'b0, REG_PULSE_MIN, 16'd0, 1'b1, 1'b0, 1'b0, 16'd0, 1'b0, 16'd0, 1'b0},
		'{1'b0, REG_PULSE_MIN, 16'd0, 1'b1, 1'b0, 1'b1, 16'h5555, 1'b0, 16'd0, 1'b0},
		'{1'b1, REG_CENTER_VALUE, 16'd0, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 16'd0, 1'b0},
		'{1'b1, REG_MOTOR_MODE, 16'd0, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 16'd0, 1'b0},
		'{1'b0, REG_PULSE_MIN, 16'd0, 1'b1, 1'b0, 1'b0, 16'd0, 1'b0, 16'd0, 1'b0},
		'{1'b0, REG_PULSE_MIN, 16'd0, 1'b1, 1'b0, 1'b0, 16'd0, 1'b0, 16'd0, 1'b0},
		'{1'b1, REG_DWELL_TICKS, 16'hFFFF, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0, 16'd0, 1'b0},
		'{1'b0, REG_PULSE_MIN, 16'd0, 1'b1, 1'b0, 1'b0, 16'd0, 1'b0, 16'd0, 1'b0},
		'{1'b0, REG_PULSE_MIN, 16'd0, 1'b1, 1'b0, 1'b1, 16'h8001, 1'b0, 16'd0, 1'b0}
	};

	function automatic longint sweep_value();
		longint c, i, s, n, d;
		c = longint'(setup.center_value);
		i = longint'(idx_q);
		s = longint'(setup.step_size);
		n = longint'(setup.step_count);
		if (!setup.motor_mode)
			return idx_q[0] ? c + i * s : c - i * s;
		if (i < n / 2)
			return c + 2 * i * s;
		d = (i > n) ? i - n : n - i;
		return c + 2 * d * s;
	endfunction

	function automatic tick_res_t advance_tick(logic start_run, logic load_manual,
		logic [ValW-1:0] manual_value);
		longint v, lo, hi;
		tick_res_t r;
		v = longint'(sp_q);
		lo = longint'(setup.pulse_min);
		hi = longint'(setup.pulse_max);
		if (load_manual)
			v = longint'(manual_value);
		if (start_run && !run_q) begin
			run_q = 1'b1;
			idx_q = '0;
			ticks_q = '0;
		end
		if (run_q && idx_q < setup.step_count) begin
			v = sweep_value();
			ticks_q = ticks_q + 1'b1;
			if (ticks_q > setup.dwell_ticks) begin
				ticks_q = '0;
				idx_q = idx_q + 1'b1;
			end
		end else if (run_q) begin
			run_q = 1'b0;
			idx_q = '0;
			v = longint'(setup.center_value);
		end
		if (v > hi)
			v = hi;
		else if (v < lo)
			v = lo;
		sp_q = v[ValW-1:0];
		r = '0;
		r.setpoint = sp_q;
		r.run_active = run_q;
		return r;
	endfunction

	always @(posedge clk) begin : scoreboard
		tick_res_t want, got;
		logic in_fire, out_fire;
		in_fire = arst_n && in_ch.valid && in_ch.ready;
		out_fire = arst_n && out_ch.valid && out_ch.ready;
		if (in_fire) begin
			want = advance_tick(in_ch.start_run, in_ch.load_manual, in_ch.manual_value);
			if (row_typed) begin
				want.setpoint = row_sp;
				want.run_active = row_run;
			end
			expected_ticks.push_back(want);
		end
		if (out_fire) begin
			got = '0;
			got.setpoint = out_ch.setpoint;
			got.run_active = out_ch.run_active;
			if (expected_ticks.size() == 0) begin
				$display("%0t: result with no transaction pending: setpoint %0d run_active %0b",
					$time, got.setpoint, got.run_active);
				mismatches++;
			end else begin
				want = expected_ticks.pop_front();
				if (got.setpoint !== want.setpoint) begin
					$display("%0t: setpoint expected %0d actual %0d", $time,
						want.setpoint, got.setpoint);
					mismatches++;
				end
				if (got.run_active !== want.run_active) begin
					$display("%0t: run_active expected %0b actual %0b", $time,
						want.run_active, got.run_active);
					mismatches++;
				end
			end
		end
		quiet_cycles = (in_fire || out_fire) ? 0 : quiet_cycles + 1;
	end

	initial begin : watchdog
		while (quiet_cycles < QuietLimit)
			@(posedge clk);
		$display("tb_servo_sweep_pattern_generator_unit failed");
		$finish;
	end

	always @(negedge clk)
		out_ch.ready = ($urandom_range(99) >= recv_stall_pct);

	task automatic apb_write(reg_idx_t idx, logic [DataW-1:0] value);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_PULSE_MIN:    setup.pulse_min = value[ValW-1:0];
			REG_PULSE_MAX:    setup.pulse_max = value[ValW-1:0];
			REG_CENTER_VALUE: setup.center_value = value[ValW-1:0];
			REG_STEP_SIZE:    setup.step_size = value[StepW-1:0];
			REG_STEP_COUNT:   setup.step_count = value[CountW-1:0];
			REG_DWELL_TICKS:  setup.dwell_ticks = value[ValW-1:0];
			REG_MOTOR_MODE:   setup.motor_mode = value[0];
			default: ;
		endcase
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic wait_for_results();
		@(negedge clk);
		in_ch.valid = 1'b0;
		while (expected_ticks.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic send_tick(tick_row_t row, int gap);
		repeat (gap) begin
			@(negedge clk);
			in_ch.valid = 1'b0;
		end
		@(negedge clk);
		in_ch.start_run = row.start_run;
		in_ch.load_manual = row.load_manual;
		in_ch.manual_value = row.manual_value;
		row_typed = row.typed;
		row_sp = row.typed_sp;
		row_run = row.typed_run;
		in_ch.valid = 1'b1;
		do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
	endtask

	task automatic pick_settings();
		logic [ValW-1:0] lo, hi, mid;
		case ($urandom_range(9))
			0: begin
				lo = 16'h0000;
				hi = 16'hFFFF;
			end
			1: begin
				lo = 16'($urandom_range(3000, 1600));
				hi = 16'($urandom_range(1500, 500));
			end
			default: begin
				lo = 16'($urandom_range(1500, 0));
				hi = 16'($urandom_range(3000, 1500));
			end
		endcase
		case ($urandom_range(9))
			0: mid = 16'h0000;
			1: mid = 16'hFFFF;
			default: mid = 16'($urandom_range(2500, 500));
		endcase
		apb_write(REG_PULSE_MIN, 32'(lo));
		apb_write(REG_PULSE_MAX, 32'(hi));
		apb_write(REG_CENTER_VALUE, 32'(mid));
		case ($urandom_range(7))
			0: apb_write(REG_STEP_SIZE, 0);
			1: apb_write(REG_STEP_SIZE, 4095);
			2: apb_write(REG_STEP_SIZE, $urandom_range(4095));
			default: apb_write(REG_STEP_SIZE, $urandom_range(200));
		endcase
		case ($urandom_range(15))
			0: apb_write(REG_STEP_COUNT, 0);
			1: apb_write(REG_STEP_COUNT, 64);
			default: apb_write(REG_STEP_COUNT, $urandom_range(12, 1));
		endcase
		case ($urandom_range(19))
			0: apb_write(REG_DWELL_TICKS, 32'h0000FFFF);
			1: apb_write(REG_DWELL_TICKS, $urandom_range(30));
			default: apb_write(REG_DWELL_TICKS, $urandom_range(4));
		endcase
		apb_write(REG_MOTOR_MODE, $urandom_range(1));
	endtask

	initial begin : stimulus
		tick_row_t row;
		int gap;
		setup = '{pulse_min: RstPulseMin, pulse_max: RstPulseMax,
			center_value: RstCenter, step_size: RstStepSize, step_count: RstStepCount,
			dwell_ticks: RstDwellTicks, motor_mode: RstMotorMode};
		sp_q = RstCenter;
		run_q = 1'b0;
		idx_q = '0;
		ticks_q = '0;
		in_ch.valid = 1'b0;
		in_ch.start_run = 1'b0;
		in_ch.load_manual = 1'b0;
		in_ch.manual_value = '0;
		out_ch.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[k]) begin
			if (directed_rows[k].wr_en) begin
				wait_for_results();
				apb_write(directed_rows[k].wr_reg, 32'(directed_rows[k].wr_val));
			end
			if (directed_rows[k].send)
				send_tick(directed_rows[k], 0);
		end

		for (int phase = 0; phase < NumPhases; phase++) begin
			wait_for_results();
			pick_settings();
			case (phase % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 84;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 84;
				end
				default: begin
					send_idle_pct = 29;
					recv_stall_pct = 29;
				end
			endcase
			for (int n = 0; n < PhaseTicks; n++) begin
				row = '0;
				row.send = 1'b1;
				row.start_run = ($urandom_range(7) == 0);
				row.load_manual = ($urandom_range(3) == 0);
				case ($urandom_range(7))
					0: row.manual_value = 16'h0000;
					1: row.manual_value = 16'hFFFF;
					default: row.manual_value = 16'($urandom_range(16'hFFFF));
				endcase
				gap = 0;
				while (gap < 40 && $urandom_range(99) < send_idle_pct)
					gap++;
				if ($urandom_range(149) == 0)
					wait_for_results();
				send_tick(row, gap);
			end
		end

		wait_for_results();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (8) @(posedge clk);
		if (mismatches == 0 && expected_ticks.size() == 0)
			$display("tb_servo_sweep_pattern_generator_unit passed");
		else
			$display("tb_servo_sweep_pattern_generator_unit failed");
		$finish;
	end

endmodule
